// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`endif

// ----- hw/rtl/stt_pkg.sv -----
// Types and constants of the software timer table.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int SLOTS       = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths on the ports.
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_FLD_W = 4;
  localparam int MS_W       = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef logic [TIME_BITS-1:0] tval_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_SCHEDULE = 2'd1,
    KIND_CANCEL   = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FIRED     = 2'd0,
    ST_SCHEDULED = 2'd1,
    ST_FULL      = 2'd2,
    ST_DONE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EVAL = 2'd2,
    S_DONE = 2'd3
  } state_e;

  // One timer entry of the memory.
  typedef struct packed {
    logic  repeat_en;
    tval_t interval;
    tval_t deadline;
    tval_t launch;
  } entry_t;

endpackage

// ----- hw/rtl/software_timer_table.sv -----
// Software timer table: a memory of timers, scanned in slot order on each tick.
// Schedule, cancel and clear give their single result in the cycle after the transaction.
// A tick reads each live slot from the memory, then evaluates and writes it back; a free
// slot is only checked and skipped. The evaluate step waits while the result port stalls.
// Reset clears all valid flip-flops at once; the memory itself needs no clearing pass.
`timescale 1ns / 1ps

module software_timer_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] now_ms, [63:32] interval_ms, [64] repeat_req, [68:65] target_slot
  input  logic [stt_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [1:0] kind
  input  logic [stt_pkg::KIND_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] slot, [35:4] elapsed_ms
  output logic [stt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [stt_pkg::STATUS_W-1:0]    m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam stt_pkg::slot_t LastSlot = stt_pkg::SLOT_W'(stt_pkg::SLOTS - 1);

  // Control registers.
  stt_pkg::state_e              state_q, state_d;
  stt_pkg::slot_t               idx_q, idx_d;
  logic [stt_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [stt_pkg::SLOTS-1:0]    valid_q, valid_d;
  logic                         pend_v_q, pend_v_d;
  logic                         m_valid_q, m_valid_d;

  // Payload registers.
  stt_pkg::tval_t               now_q, now_d;
  stt_pkg::slot_t               pend_slot_q, pend_slot_d;
  stt_pkg::tval_t               pend_el_q, pend_el_d;
  stt_pkg::status_e             out_status_q, out_status_d;
  logic [stt_pkg::SLOT_FLD_W-1:0] out_slot_q, out_slot_d;
  logic [stt_pkg::MS_W-1:0]     out_el_q, out_el_d;
  logic                         out_last_q, out_last_d;

  // Memory port signals.
  stt_pkg::entry_t              mem [stt_pkg::SLOTS];
  stt_pkg::entry_t              rdata_q;
  stt_pkg::entry_t              wr_data;
  stt_pkg::slot_t               wr_addr;
  logic                         wr_en;
  logic                         rd_en;

  // Input field decode.
  stt_pkg::kind_e               in_kind;
  stt_pkg::tval_t               in_now;
  stt_pkg::tval_t               in_ival;
  logic                         in_rep;
  logic [stt_pkg::SLOT_FLD_W-1:0] in_tgt;
  logic                         in_accept;
  logic                         out_free;

  // Lowest free slot search and tick evaluation.
  stt_pkg::slot_t               free_slot;
  logic                         free_found;
  stt_pkg::tval_t               diff;
  logic                         fire;
  logic                         stall;
  logic                         idx_last;

  assign in_kind   = stt_pkg::kind_e'(s_axis_tuser_i);
  assign in_now    = stt_pkg::tval_t'(s_axis_tdata_i[31:0]);
  assign in_ival   = stt_pkg::tval_t'(s_axis_tdata_i[63:32]);
  assign in_rep    = s_axis_tdata_i[64];
  assign in_tgt    = s_axis_tdata_i[68:65];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == stt_pkg::S_IDLE) && out_free;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = stt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot  = stt_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // Deadline is strictly passed when the wrapped difference is positive.
  assign diff     = now_q - rdata_q.deadline;
  assign fire     = (diff != '0) && !diff[stt_pkg::TIME_BITS-1] &&
                    (cnt_q < stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS));
  assign stall    = fire && pend_v_q && !out_free;
  assign idx_last = (idx_q == LastSlot);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stt_pkg::S_IDLE: begin
        if (in_accept && in_kind == stt_pkg::KIND_TICK) state_d = stt_pkg::S_READ;
      end
      stt_pkg::S_READ: begin
        if (valid_q[idx_q]) state_d = stt_pkg::S_EVAL;
        else if (idx_last)  state_d = stt_pkg::S_DONE;
      end
      stt_pkg::S_EVAL: begin
        if (!stall) state_d = idx_last ? stt_pkg::S_DONE : stt_pkg::S_READ;
      end
      stt_pkg::S_DONE: begin
        if (out_free) state_d = stt_pkg::S_IDLE;
      end
      default: state_d = stt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    pend_v_d     = pend_v_q;
    pend_slot_d  = pend_slot_q;
    pend_el_d    = pend_el_q;
    now_d        = now_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_el_d     = out_el_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rdata_q;

    case (state_q)
      stt_pkg::S_IDLE: begin
        if (in_accept) begin
          out_el_d   = '0;
          out_last_d = 1'b1;
          out_slot_d = '0;
          case (in_kind)
            stt_pkg::KIND_TICK: begin
              m_valid_d = 1'b0;
              idx_d     = '0;
              cnt_d     = '0;
              pend_v_d  = 1'b0;
              now_d     = in_now;
            end
            stt_pkg::KIND_SCHEDULE: begin
              m_valid_d = 1'b1;
              if (free_found) begin
                valid_d[free_slot] = 1'b1;
                wr_en              = 1'b1;
                wr_addr            = free_slot;
                wr_data.repeat_en  = in_rep;
                wr_data.interval   = in_ival;
                wr_data.deadline   = in_now + in_ival;
                wr_data.launch     = in_now;
                out_status_d       = stt_pkg::ST_SCHEDULED;
                out_slot_d         = stt_pkg::SLOT_FLD_W'(free_slot);
              end else begin
                out_status_d = stt_pkg::ST_FULL;
              end
            end
            stt_pkg::KIND_CANCEL: begin
              m_valid_d    = 1'b1;
              if (32'(in_tgt) < 32'(stt_pkg::SLOTS)) begin
                valid_d[stt_pkg::SLOT_W'(in_tgt)] = 1'b0;
              end
              out_status_d = stt_pkg::ST_DONE;
              out_slot_d   = in_tgt;
            end
            default: begin
              m_valid_d    = 1'b1;
              valid_d      = '0;
              out_status_d = stt_pkg::ST_DONE;
            end
          endcase
        end
      end

      stt_pkg::S_READ: begin
        if (valid_q[idx_q]) begin
          rd_en = 1'b1;
        end else if (!idx_last) begin
          idx_d = idx_q + stt_pkg::SLOT_W'(1);
        end
      end

      stt_pkg::S_EVAL: begin
        if (!stall) begin
          if (!idx_last) idx_d = idx_q + stt_pkg::SLOT_W'(1);
          if (fire) begin
            // Re-arm a periodic timer, free a one-shot timer.
            wr_en          = 1'b1;
            wr_data.launch = now_q;
            if (rdata_q.repeat_en) wr_data.deadline = now_q + rdata_q.interval;
            valid_d[idx_q] = rdata_q.repeat_en;
            // The held firing is not the final one: send it on.
            if (pend_v_q) begin
              m_valid_d    = 1'b1;
              out_status_d = stt_pkg::ST_FIRED;
              out_slot_d   = stt_pkg::SLOT_FLD_W'(pend_slot_q);
              out_el_d     = stt_pkg::MS_W'(pend_el_q);
              out_last_d   = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_slot_d = idx_q;
            pend_el_d   = now_q - rdata_q.launch;
            cnt_d       = cnt_q + stt_pkg::CNT_W'(1);
          end
        end
      end

      stt_pkg::S_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          if (pend_v_q) begin
            out_status_d = stt_pkg::ST_FIRED;
            out_slot_d   = stt_pkg::SLOT_FLD_W'(pend_slot_q);
            out_el_d     = stt_pkg::MS_W'(pend_el_q);
          end else begin
            out_status_d = stt_pkg::ST_DONE;
            out_slot_d   = '0;
            out_el_d     = '0;
          end
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stt_pkg::S_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      pend_v_q  <= pend_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    pend_slot_q  <= pend_slot_d;
    pend_el_q    <= pend_el_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_el_q     <= out_el_d;
    out_last_q   <= out_last_d;
  end

  // Timer memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[idx_q];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_el_q, out_slot_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- hw/rtl/stt_checker.sv -----
// Port checker of the software timer table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [stt_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input logic [stt_pkg::KIND_W-1:0]      s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [stt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic [stt_pkg::STATUS_W-1:0]    m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);

  logic open_q;
  logic in_txn;
  logic out_txn;
  logic out_final;

  assign in_txn    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_txn   = m_axis_tvalid_o && m_axis_tready_i;
  assign out_final = out_txn && m_axis_tlast_o;

  // An input transaction is open until its final result transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (in_txn) begin
      open_q <= 1'b1;
    end else if (out_final) begin
      open_q <= 1'b0;
    end
  end

  // A stalled result holds still.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
    $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // Only firings may be followed by more results of the same input.
  `ASSERT_NEVER(a_single_last, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o != stt_pkg::ST_FIRED && !m_axis_tlast_o)

  // Results other than firings carry no elapsed time.
  `ASSERT_NEVER(a_elapsed_zero, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o != stt_pkg::ST_FIRED &&
    m_axis_tdata_o[35:4] != '0)

  // The next input is taken only after the previous one is answered in full.
  `ASSERT_NEVER(a_one_open, clk_i, rst_ni, in_txn && open_q && !out_final)

  // No result appears without an open input.
  `ASSERT_NEVER(a_no_orphan, clk_i, rst_ni, out_txn && !open_q)

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
